>>> design/sha1mh_pkg.sv
// Shared types, constants and round functions of the SHA-1 message hasher.
package sha1mh_pkg;

  localparam int unsigned NumWords = 5;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } sha1mh_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } sha1mh_state_t;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [NumWords-1:0][31:0] InitChain = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [6:0] LastRound   = 7'd79;
  localparam logic [5:0] PadLastByte = 6'd55;
  localparam logic [5:0] BlockLast   = 6'd63;
  localparam logic [2:0] LastIndex   = 3'd4;
  localparam logic [7:0] PadMarker   = 8'h80;

  function automatic logic [31:0] sha1mh_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      res = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic logic [31:0] sha1mh_k(input logic [6:0] rnd);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = K0;
    end else if (rnd < 7'd40) begin
      res = K1;
    end else if (rnd < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

>>> design/sha1mh_front.sv
// Input side: accepts items, drops empty non-final ones, queues the rest.
module sha1mh_front import sha1mh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  output logic        cmd_valid,
  output sha1mh_cmd_t cmd,
  input  logic        cmd_pop
);

  sha1mh_cmd_t q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  logic        pop;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall && (in_has_byte || in_last_byte);
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{data: in_message_byte, has: in_has_byte, last: in_last_byte};
    end
  end

endmodule

>>> design/sha1mh_back.sv
// Block assembly, padding, 80-round compression and digest output.
module sha1mh_back import sha1mh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  sha1mh_cmd_t cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha1mh_state_t state_r, state_nxt;

  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] chain_r [NumWords];
  logic [63:0] bit_len_r;
  logic [5:0]  off_r;
  logic [6:0]  rnd_r;
  logic        pad_r;
  logic        first_pad_r;
  logic        final_r;
  logic [2:0]  idx_r;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_index_r;
  logic        out_last_r;

  logic        out_load;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [31:0] t_sum;
  logic [31:0] w_new;
  logic        comp_start;

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_index_r;
  assign out_last_word   = out_last_r;

  assign t_sum = {a_r[26:0], a_r[31:27]} + sha1mh_f(rnd_r, b_r, c_r, d_r) + e_r
               + sha1mh_k(rnd_r) + w_r[0];
  assign w_new = {w_r[13][30:0] ^ w_r[8][30:0] ^ w_r[2][30:0] ^ w_r[0][30:0],
                  w_r[13][31] ^ w_r[8][31] ^ w_r[2][31] ^ w_r[0][31]};
  assign comp_start = (state_nxt == ST_COMP) && (state_r != ST_COMP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.has && off_r == BlockLast) begin
            state_nxt = ST_COMP;
          end else if (cmd.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (off_r == PadLastByte) begin
          state_nxt = ST_LEN;
        end else if (off_r == BlockLast) begin
          state_nxt = ST_COMP;
        end
      end
      ST_LEN:  state_nxt = ST_COMP;
      ST_COMP: begin
        if (rnd_r == LastRound) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_load && idx_r == LastIndex) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    out_load = 1'b0;
    wr_en    = 1'b0;
    wr_byte  = cmd.data;
    unique case (state_r)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
        wr_en   = cmd_valid && cmd.has;
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = first_pad_r ? PadMarker : 8'h00;
      end
      ST_OUT:  out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_len_r   <= 64'd0;
      off_r       <= 6'd0;
      rnd_r       <= 7'd0;
      pad_r       <= 1'b0;
      first_pad_r <= 1'b0;
      final_r     <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NumWords; i++) begin
        chain_r[i] <= InitChain[i];
      end
    end else begin
      state_r <= state_nxt;
      if (comp_start) begin
        rnd_r <= 7'd0;
      end else if (state_r == ST_COMP) begin
        rnd_r <= rnd_r + 7'd1;
      end
      if (wr_en) begin
        off_r <= off_r + 6'd1;
      end
      if (state_r == ST_IDLE && cmd_valid) begin
        if (cmd.has) begin
          bit_len_r <= bit_len_r + 64'd8;
        end
        if (cmd.last) begin
          pad_r       <= 1'b1;
          first_pad_r <= 1'b1;
        end
      end
      if (state_r == ST_PAD) begin
        first_pad_r <= 1'b0;
      end
      if (state_r == ST_LEN) begin
        final_r <= 1'b1;
        off_r   <= 6'd0;
      end
      if (state_r == ST_ADD) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (out_load) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r == LastIndex) begin
          idx_r     <= 3'd0;
          bit_len_r <= 64'd0;
          off_r     <= 6'd0;
          pad_r     <= 1'b0;
          final_r   <= 1'b0;
          for (int i = 0; i < NumWords; i++) begin
            chain_r[i] <= InitChain[i];
          end
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (off_r[1:0])
        2'd0:    w_r[off_r[5:2]][31:24] <= wr_byte;
        2'd1:    w_r[off_r[5:2]][23:16] <= wr_byte;
        2'd2:    w_r[off_r[5:2]][15:8]  <= wr_byte;
        default: w_r[off_r[5:2]][7:0]   <= wr_byte;
      endcase
    end
    if (state_r == ST_LEN) begin
      w_r[14] <= bit_len_r[63:32];
      w_r[15] <= bit_len_r[31:0];
    end
    if (state_r == ST_COMP) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end else if (comp_start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end
    if (out_load) begin
      out_word_r  <= chain_r[idx_r];
      out_index_r <= idx_r;
      out_last_r  <= (idx_r == LastIndex);
    end
  end

endmodule

>>> design/sha1_message_hasher_core.sv
// SHA-1 message hasher, top level.
// Message bytes enter one per item; the front queues up to two items while the
// back is busy. The back writes one byte per cycle while it is idle and an item
// is queued into a 64-byte block register and, on each full block, runs the 80
// rounds one per cycle, then adds the result into the chain; intake is held while
// the back compresses, pads or emits. A final item pads one byte per cycle up to
// byte 55, writes the bit length, compresses once (twice when fewer than nine
// bytes are left in the block), then emits the five digest words, H0 first, on
// consecutive cycles while out_stall is low, and starts the next message.
module sha1_message_hasher_core import sha1mh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic        cmd_valid;
  sha1mh_cmd_t cmd;
  logic        cmd_pop;

  sha1mh_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_byte (in_message_byte),
    .in_has_byte     (in_has_byte),
    .in_last_byte    (in_last_byte),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  sha1mh_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

>>> design/sha1mh_checker.sv
// Port-level checks on the digest output of the SHA-1 message hasher.
module sha1mh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("stalled digest item changed");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd4)))
    else $error("last_word does not match word_index");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_index <= 3'd4))
    else $error("word_index out of range");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && (out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest words not consecutive");

endmodule

bind sha1_message_hasher_core sha1mh_checker u_sha1mh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);

>>> sim/sha1_message_hasher_core_tb.sv
// Self-checking testbench for the SHA-1 message hasher core with a built-in digest predictor.
module sha1_message_hasher_core_tb;

  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned TailCycles = 400;
  localparam logic [4:0][31:0] Sha1Iv = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       last;
  } byte_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_message_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  byte_item_t   byte_items_q[$];
  digest_word_t digest_words_q[$];
  byte_item_t   cur_item;

  logic [31:0] hash_chain [5];
  logic [7:0]  hash_block [64];
  logic [63:0] hash_bit_len;

  int unsigned fail_count = 0;
  int unsigned counted_items = 0;
  int unsigned message_count = 0;
  int unsigned words_seen = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned idle_cycles = 0;

  sha1_message_hasher_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_byte (in_message_byte),
    .in_has_byte     (in_has_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic start_message_hash();
    for (int i = 0; i < 5; i++) hash_chain[i] = Sha1Iv[i];
    hash_bit_len = 64'd0;
  endtask

  task automatic sha1_compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int r = 0; r < 16; r++) begin
      w[r] = {hash_block[4*r], hash_block[4*r+1], hash_block[4*r+2], hash_block[4*r+3]};
    end
    for (int r = 16; r < 80; r++) begin
      x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {x[30:0], x[31]};
    end
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2];
    d = hash_chain[3]; e = hash_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5a827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c;
    hash_chain[3] += d; hash_chain[4] += e;
  endtask

  task automatic sha1_absorb_item(input byte_item_t item);
    int unsigned  off;
    logic [63:0]  msg_len;
    digest_word_t dw;
    off = 32'(hash_bit_len[8:3]);
    if (item.has) begin
      hash_block[off] = item.data;
      hash_bit_len += 64'd8;
      off++;
      if (off == 64) begin
        sha1_compress_block();
        off = 0;
      end
    end
    if (item.last) begin
      msg_len = hash_bit_len;
      hash_block[off] = 8'h80;
      off++;
      if (off > 56) begin
        while (off < 64) begin
          hash_block[off] = 8'h00;
          off++;
        end
        sha1_compress_block();
        off = 0;
      end
      while (off < 56) begin
        hash_block[off] = 8'h00;
        off++;
      end
      for (int i = 0; i < 8; i++) hash_block[56+i] = msg_len[63-8*i -: 8];
      sha1_compress_block();
      for (int i = 0; i < 5; i++) begin
        dw.word  = hash_chain[i];
        dw.index = 3'(i);
        dw.last  = (i == 4);
        digest_words_q.push_back(dw);
      end
      start_message_hash();
    end
  endtask

  task automatic queue_item(input logic [7:0] data, input logic has, input logic last);
    byte_item_t item;
    item.data = data;
    item.has  = has;
    item.last = last;
    byte_items_q.push_back(item);
    if (has || last) counted_items++;
    if (last) message_count++;
  endtask

  task automatic queue_message(input int unsigned len, input bit empty_final);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
      queue_item(8'($urandom), 1'b1, !empty_final && (i == len - 1));
    end
    if (empty_final || len == 0) queue_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      start_message_hash();
      for (int i = 0; i < 64; i++) hash_block[i] = 8'h00;
    end else begin
      if (in_valid && !in_stall) sha1_absorb_item(cur_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (byte_items_q.size() > 0) begin
          cur_item = byte_items_q.pop_front();
          in_valid        <= 1'b1;
          in_message_byte <= cur_item.data;
          in_has_byte     <= cur_item.has;
          in_last_byte    <= cur_item.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    digest_word_t exp_word;
    logic         next_stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (digest_words_q.size() == 0) begin
          $error("unexpected digest item: word %h index %0d", out_digest_word, out_word_index);
          fail_count++;
        end else begin
          exp_word = digest_words_q.pop_front();
          if (out_digest_word !== exp_word.word) begin
            $error("digest_word: expected %h, got %h", exp_word.word, out_digest_word);
            fail_count++;
          end
          if (out_word_index !== exp_word.index) begin
            $error("word_index: expected %0d, got %0d", exp_word.index, out_word_index);
            fail_count++;
          end
          if (out_last_word !== exp_word.last) begin
            $error("last_word: expected %b, got %b", exp_word.last, out_last_word);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (!hold_done && words_seen >= 12) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        next_stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(5, 60);
        end
        mode_left--;
        case (stall_mode)
          0: next_stall = 1'b0;
          1: next_stall = ($urandom_range(0, 3) == 0);
          default: next_stall = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_stall <= next_stall;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned boundary_lens [6];
    int unsigned pick;
    int unsigned len;
    boundary_lens = '{55, 56, 63, 64, 119, 120};

    // empty message, ignored bytes, "abc", single bytes, empty final after bytes
    queue_item(8'hff, 1'b0, 1'b1);
    queue_item(8'h00, 1'b0, 1'b0);
    queue_item(8'h5a, 1'b0, 1'b0);
    queue_item(8'h61, 1'b1, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1);
    queue_item(8'h00, 1'b1, 1'b1);
    queue_item(8'hff, 1'b1, 1'b1);
    queue_item(8'h01, 1'b1, 1'b0);
    queue_item(8'hfe, 1'b0, 1'b0);
    queue_item(8'hfe, 1'b1, 1'b0);
    queue_item(8'h55, 1'b0, 1'b1);

    foreach (boundary_lens[i]) queue_message(boundary_lens[i], $urandom_range(0, 1));
    while (counted_items < 500) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      len = $urandom_range(0, 12);
      else if (pick < 80) len = $urandom_range(50, 70);
      else if (pick < 95) len = $urandom_range(13, 40);
      else                len = $urandom_range(65, 140);
      queue_message(len, $urandom_range(0, 3) == 0);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_items_q.size() != 0 || in_valid) @(posedge clk);
    while (digest_words_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sha1mh_pkg.sv
design/sha1mh_front.sv
design/sha1mh_back.sv
design/sha1_message_hasher_core.sv
design/sha1mh_checker.sv
sim/sha1_message_hasher_core_tb.sv
